// File: src/bdlp_pkg.sv
`default_nettype none

package bdlp_pkg;

  // timestamp and register width
  localparam int unsigned TimeW = 32;

  // register reset values
  localparam logic [TimeW-1:0] DebounceMsRst  = TimeW'(100);
  localparam logic [TimeW-1:0] LongPressMsRst = TimeW'(500);

  // configuration register indexes
  typedef enum logic [0:0] {
    RegDebounceMs  = 1'b0,
    RegLongPressMs = 1'b1
  } cfg_reg_e;

  // one result word
  typedef struct packed {
    logic level;
    logic press_edge;
    logic release_edge;
    logic held;
    logic long_press;
  } poll_res_t;

endpackage

`default_nettype wire

// File: src/bdlp_cfg.sv
`default_nettype none

module bdlp_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire bdlp_pkg::cfg_reg_e         cfg_index_i,
  input  wire logic [bdlp_pkg::TimeW-1:0] cfg_data_i,
  output logic [bdlp_pkg::TimeW-1:0]      debounce_ms_o,
  output logic [bdlp_pkg::TimeW-1:0]      long_press_ms_o
);
  import bdlp_pkg::*;

  logic [TimeW-1:0] debounce_ms_q, debounce_ms_d;
  logic [TimeW-1:0] long_press_ms_q, long_press_ms_d;

  // register write decode
  always_comb begin
    debounce_ms_d   = debounce_ms_q;
    long_press_ms_d = long_press_ms_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDebounceMs:  debounce_ms_d   = cfg_data_i;
        RegLongPressMs: long_press_ms_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q   <= DebounceMsRst;
      long_press_ms_q <= LongPressMsRst;
    end else begin
      debounce_ms_q   <= debounce_ms_d;
      long_press_ms_q <= long_press_ms_d;
    end
  end

  assign debounce_ms_o   = debounce_ms_q;
  assign long_press_ms_o = long_press_ms_q;

endmodule

`default_nettype wire

// File: src/bdlp_poll.sv
`default_nettype none

module bdlp_poll (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic                       raw_pressed_i,
  input  wire logic [bdlp_pkg::TimeW-1:0] now_ms_i,
  input  wire logic [bdlp_pkg::TimeW-1:0] debounce_ms_i,
  input  wire logic [bdlp_pkg::TimeW-1:0] long_press_ms_i,
  output bdlp_pkg::poll_res_t             res_o
);
  import bdlp_pkg::*;

  logic             raw_now_q;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] bounce_start_q, bounce_start_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic             long_done_q, long_done_d;
  logic [TimeW-1:0] bounce_age;
  logic [TimeW-1:0] press_age;
  logic             pe, re, hd, lp, done_mid;

  // elapsed times, wrapping modulo 2^32
  assign bounce_age = now_ms_i - bounce_start_q;
  assign press_age  = now_ms_i - press_start_q;

  // debounce, edges and long-press detection for one poll
  always_comb begin
    bounce_start_d = bounce_start_q;
    stable_d       = stable_q;
    if (raw_pressed_i != raw_now_q) begin
      bounce_start_d = now_ms_i;
    end else if (bounce_age >= debounce_ms_i) begin
      stable_d = raw_pressed_i;
    end
    pe            = stable_d & ~stable_q;
    re            = ~stable_d & stable_q;
    hd            = stable_d & stable_q;
    press_start_d = pe ? now_ms_i : press_start_q;
    done_mid      = (pe | re) ? 1'b0 : long_done_q;
    // a held poll never coincides with a press edge, so the old start time holds
    lp            = hd & ~done_mid & (press_age >= long_press_ms_i);
    long_done_d   = done_mid | lp;

    res_o.level        = stable_d;
    res_o.press_edge   = pe;
    res_o.release_edge = re;
    res_o.held         = hd;
    res_o.long_press   = lp;
  end

  // poll state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_now_q      <= 1'b0;
      stable_q       <= 1'b0;
      bounce_start_q <= '0;
      press_start_q  <= '0;
      long_done_q    <= 1'b0;
    end else if (step_i) begin
      raw_now_q      <= raw_pressed_i;
      stable_q       <= stable_d;
      bounce_start_q <= bounce_start_d;
      press_start_q  <= press_start_d;
      long_done_q    <= long_done_d;
    end
  end

endmodule

`default_nettype wire

// File: src/button_debounce_long_press.sv
// Debounced push button with one-shot long-press pulse. Each input word is one
// poll: the raw pressed level and a free-running millisecond timestamp. Every
// poll gives exactly one result word with the debounced level, press and
// release edges, the held flag and a long-press pulse that fires at most once
// per press. A word waits in the input register and is then evaluated and
// written to the result register, so a new poll is taken every cycle while
// results are consumed. When both the input and the result register hold a
// word, in_ready_o follows out_ready_i in the same cycle. Registers: index 0
// is the debounce time (reset 100 ms), index 1 the long-press time (reset
// 500 ms); write them only while no poll is in flight.
`default_nettype none

module button_debounce_long_press (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration writes
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire bdlp_pkg::cfg_reg_e         cfg_index_i,
  input  wire logic [bdlp_pkg::TimeW-1:0] cfg_data_i,
  // poll words
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       raw_pressed_i,
  input  wire logic [bdlp_pkg::TimeW-1:0] now_ms_i,
  // result words
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            level_o,
  output logic                            press_edge_o,
  output logic                            release_edge_o,
  output logic                            held_o,
  output logic                            long_press_o
);
  import bdlp_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic             raw_q;
  logic [TimeW-1:0] now_q;
  logic             out_valid_q, out_valid_d;
  poll_res_t        res_q, res_d;
  logic             advance;
  logic [TimeW-1:0] debounce_ms;
  logic [TimeW-1:0] long_press_ms;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  bdlp_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .debounce_ms_o   (debounce_ms),
    .long_press_ms_o (long_press_ms)
  );

  // handshake: the input word moves on when the result slot is free or drained
  assign advance     = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~in_valid_q | advance;
  assign in_valid_d  = (in_valid_i & in_ready_o) | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~out_ready_i);

  // evaluation of the registered poll
  bdlp_poll u_poll (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .raw_pressed_i   (raw_q),
    .now_ms_i        (now_q),
    .debounce_ms_i   (debounce_ms),
    .long_press_ms_i (long_press_ms),
    .res_o           (res_d)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i & in_ready_o) begin
      raw_q <= raw_pressed_i;
      now_q <= now_ms_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_o        = res_q.level;
  assign press_edge_o   = res_q.press_edge;
  assign release_edge_o = res_q.release_edge;
  assign held_o         = res_q.held;
  assign long_press_o   = res_q.long_press;

`ifndef SYNTHESIS
  // a long press is only reported while the button is held
  a_long_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!long_press_o || held_o))
    else $error("long press without held");

  // edges agree with the debounced level and exclude each other
  a_edge_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!press_edge_o || (level_o && !held_o))
                 && (!release_edge_o || (!level_o && !press_edge_o)))
    else $error("edge flags inconsistent with level");

  // a waiting input word stays when the result slot is blocked
  a_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(now_q) && $stable(raw_q))
    else $error("stalled input word lost");

  // a new result only appears after an input word was present
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result without input word");
`endif

endmodule

`default_nettype wire

// File: test/button_debounce_long_press_tb.sv
`timescale 1ns / 1ps

module button_debounce_long_press_tb;
  import bdlp_pkg::*;

  localparam int unsigned IdleLimit = 1000;

  // debounce and long-press tracker with its own copy of the registers
  class debounce_board;
    logic [TimeW-1:0] debounce_ms;
    logic [TimeW-1:0] long_press_ms;
    bit               raw_cur;
    bit               raw_prev;
    bit               level_cur;
    bit               level_prev;
    bit               long_seen;
    logic [TimeW-1:0] bounce_t;
    logic [TimeW-1:0] press_t;
    poll_res_t        pending_results[$];
    int unsigned      errors;

    function new();
      debounce_ms   = DebounceMsRst;
      long_press_ms = LongPressMsRst;
      raw_cur       = 1'b0;
      raw_prev      = 1'b0;
      level_cur     = 1'b0;
      level_prev    = 1'b0;
      long_seen     = 1'b0;
      bounce_t      = '0;
      press_t       = '0;
      errors        = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [TimeW-1:0] data);
      case (idx)
        RegDebounceMs:  debounce_ms = data;
        RegLongPressMs: long_press_ms = data;
        default: ;
      endcase
    endfunction

    // one poll: shift the raw sample, debounce, then edges and long press
    function void note_poll(bit raw, logic [TimeW-1:0] ms);
      poll_res_t res;
      logic [TimeW-1:0] elapsed;
      level_prev = level_cur;
      raw_prev   = raw_cur;
      raw_cur    = raw;
      elapsed    = ms - bounce_t;
      if (raw_cur != raw_prev) begin
        bounce_t = ms;
      end else if (elapsed >= debounce_ms) begin
        level_cur = raw_cur;
      end
      res.level        = level_cur;
      res.press_edge   = level_cur && !level_prev;
      res.release_edge = !level_cur && level_prev;
      res.held         = level_cur && level_prev;
      res.long_press   = 1'b0;
      if (res.press_edge) begin
        press_t   = ms;
        long_seen = 1'b0;
      end
      if (res.release_edge) begin
        long_seen = 1'b0;
      end
      elapsed = ms - press_t;
      if (res.held && !long_seen && elapsed >= long_press_ms) begin
        long_seen      = 1'b1;
        res.long_press = 1'b1;
      end
      pending_results.push_back(res);
    endfunction

    function void cmp_bit(string name, bit exp_v, logic act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0b, got %0b", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(poll_res_t got);
      poll_res_t want;
      if (pending_results.size() == 0) begin
        $error("result word with no poll pending");
        errors++;
      end else begin
        want = pending_results.pop_front();
        cmp_bit("level", want.level, got.level);
        cmp_bit("press_edge", want.press_edge, got.press_edge);
        cmp_bit("release_edge", want.release_edge, got.release_edge);
        cmp_bit("held", want.held, got.held);
        cmp_bit("long_press", want.long_press, got.long_press);
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  typedef struct {
    logic [TimeW-1:0] deb;
    logic [TimeW-1:0] lp;
    int unsigned      step;
  } phase_t;

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_valid_i    = 1'b0;
  logic             cfg_ready_o;
  cfg_reg_e         cfg_index_i    = RegDebounceMs;
  logic [TimeW-1:0] cfg_data_i     = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic             raw_pressed_i  = 1'b0;
  logic [TimeW-1:0] now_ms_i       = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic             level_o;
  logic             press_edge_o;
  logic             release_edge_o;
  logic             held_o;
  logic             long_press_o;

  debounce_board    board;
  logic [TimeW-1:0] clock_ms;
  int unsigned      burst_left;
  int unsigned      polls_sent;

  button_debounce_long_press dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_pressed_i  (raw_pressed_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .level_o        (level_o),
    .press_edge_o   (press_edge_o),
    .release_edge_o (release_edge_o),
    .held_o         (held_o),
    .long_press_o   (long_press_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one poll word, sent in bursts with random gaps
  task automatic send_poll(input bit raw, input logic [TimeW-1:0] ms);
    in_valid_i    <= 1'b1;
    raw_pressed_i <= raw;
    now_ms_i      <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_poll(raw, ms);
    polls_sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  // hold off polls until every result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [TimeW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // press with contact bounce, hold, release with bounce, rest
  task automatic press_cycle(input int unsigned step_max);
    int unsigned nb;
    int unsigned n;
    nb = $urandom_range(0, 3);
    for (int i = 0; i < nb; i++) begin
      clock_ms += $urandom_range(0, step_max / 4 + 1);
      send_poll(!i[0], clock_ms);
    end
    n = $urandom_range(1, 30);
    for (int i = 0; i < n; i++) begin
      clock_ms += $urandom_range(0, step_max);
      send_poll(1'b1, clock_ms);
    end
    nb = $urandom_range(0, 3);
    for (int i = 0; i < nb; i++) begin
      clock_ms += $urandom_range(0, step_max / 4 + 1);
      send_poll(i[0], clock_ms);
    end
    n = $urandom_range(1, 15);
    for (int i = 0; i < n; i++) begin
      clock_ms += $urandom_range(0, step_max);
      send_poll(1'b0, clock_ms);
    end
  endtask

  // random polls: full-range times, time jumps and wrap crossings
  task automatic poll_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 2))
        0: clock_ms = $urandom;
        1: clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
        default: clock_ms += $urandom_range(0, 3);
      endcase
      send_poll($urandom_range(0, 1), clock_ms);
    end
  endtask

  // receiver: checks words and stalls on its own pattern
  initial begin
    int unsigned cyc;
    int unsigned mode;
    int unsigned stall;
    cyc   = 0;
    mode  = 0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        board.check_result(poll_res_t'({level_o, press_edge_o, release_edge_o,
                                        held_o, long_press_o}));
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= (cyc % 4 == 0);
        default: begin
          if (stall > 0) begin
            stall--;
            out_ready_i <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 15);
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    int unsigned idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    phase_t      phases[8];
    int unsigned target;
    board      = new();
    clock_ms   = '0;
    burst_left = 5;
    polls_sent = 0;

    phases[0] = '{DebounceMsRst, LongPressMsRst, 60};
    phases[1] = '{32'd0, 32'd0, 3};
    phases[2] = '{32'd5, 32'd40, 4};
    phases[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 60};
    phases[4] = '{32'd1, 32'hFFFF_FFFF, 3};
    phases[5] = '{32'hFFFF_FFFF, 32'd0, 3};
    phases[6] = '{32'd20, 32'd150, 15};
    phases[7] = '{$urandom_range(0, 30), $urandom_range(0, 300), 10};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: debounce exactly at the limit, long press at the limit
    send_poll(1'b0, 32'd0);
    send_poll(1'b1, 32'd10);
    send_poll(1'b1, 32'd109);
    send_poll(1'b1, 32'd110);
    send_poll(1'b1, 32'd609);
    send_poll(1'b1, 32'd610);
    // time running backwards, still held with the pulse already given
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd5);
    send_poll(1'b0, 32'd104);
    send_poll(1'b0, 32'd105);

    // zero debounce and zero long press
    drain();
    write_reg(RegDebounceMs, 32'd0);
    write_reg(RegLongPressMs, 32'd0);
    send_poll(1'b1, 32'h8000_0000);
    send_poll(1'b1, 32'h8000_0000);
    send_poll(1'b1, 32'h8000_0000);
    send_poll(1'b0, 32'h7FFF_FFFF);
    send_poll(1'b0, 32'h7FFF_FFFF);

    // largest times: accept only on the full wrap distance
    drain();
    write_reg(RegDebounceMs, 32'hFFFF_FFFF);
    write_reg(RegLongPressMs, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'd0);
    send_poll(1'b1, 32'hFFFF_FFFE);
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'hFFFF_FFFD);
    send_poll(1'b1, 32'hFFFF_FFFE);
    send_poll(1'b0, 32'h5555_5555);
    send_poll(1'b1, 32'hAAAA_AAAA);

    // random phases, one register setting each
    foreach (phases[p]) begin
      drain();
      write_reg(RegDebounceMs, phases[p].deb);
      write_reg(RegLongPressMs, phases[p].lp);
      target = polls_sent + 225;
      while (polls_sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          poll_noise();
        end else begin
          press_cycle(phases[p].step);
        end
        if ($urandom_range(0, 30) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
